// ----- src/fvnh_pkg.sv -----
`default_nettype none
package fvnh_pkg;

    localparam int CHUNK_EDGE_DEF  = 32;
    localparam int MAX_OCTAVES_DEF = 16;
    localparam int CURVE_BITS_DEF  = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OCTAVES    = 3'd0,
        REG_AMPLITUDE  = 3'd1,
        REG_SMOOTHNESS = 3'd2,
        REG_OFFSET     = 3'd3,
        REG_ROUGHNESS  = 3'd4,
        REG_SEED       = 3'd5,
        REG_WATER      = 3'd6
    } t_cfg_idx;

    localparam logic [4:0]         RST_OCTAVES    = 5'd5;
    localparam logic [9:0]         RST_AMPLITUDE  = 10'd120;
    localparam logic [15:0]        RST_SMOOTHNESS = 16'd1035;
    localparam logic signed [9:0]  RST_OFFSET     = 10'sd0;
    localparam logic [15:0]        RST_ROUGHNESS  = 16'd49152;
    localparam logic [31:0]        RST_SEED       = 32'd0;
    localparam logic [7:0]         RST_WATER      = 8'd64;

    localparam int MU_W = 17;
    localparam int WT_W = 17;

    localparam logic [31:0]        HASH_MUL  = 32'd60493;
    localparam logic [31:0]        HASH_ADD1 = 32'd19990303;
    localparam logic [31:0]        HASH_ADD2 = 32'd1376312589;
    localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
    localparam logic [63:0]        HALF_ARC  = 64'd1685774664;
    localparam logic [WT_W-1:0]    WT_ONE    = 17'd65536;

    // final scaling: num / (105 * 2^22), reciprocal exact for 27-bit dividends
    localparam int          DEN_SHIFT   = 22;
    localparam longint     DEN_HALF    = 64'sd220200960;
    localparam longint     SAT_LIM     = 64'sd461794883665920;
    localparam int          QUOT_W      = 27;
    localparam logic [27:0] RECIP       = 28'd163617802;
    localparam int          RECIP_SHIFT = 34;
    localparam int          AMP_K       = 32256;
    localparam int          OFF_K       = 26880;
    localparam int          SCALE_K     = 50;
    localparam int          OUT_W       = 20;
    localparam logic [19:0] OUT_MAX     = 20'hFFFFF;
    localparam logic [19:0] OUT_ONE     = 20'd256;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_ctl;

    // (1 - cos(pi*f)) / 2 as sin^2, Taylor series in Q30, rounded to Q16
    function automatic logic [MU_W-1:0] curve_mu(input int unsigned idx,
                                                 input int unsigned bits);
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sq;
        phi  = (64'(idx) * HALF_ARC) >> bits;
        phi2 = (phi * phi) >> 30;
        term = ((phi * phi2) >> 30) / 6;
        sum  = phi - term;
        term = ((term * phi2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * phi2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * phi2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * phi2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * phi2) >> 30) / 156;
        sum  = sum + term;
        term = ((term * phi2) >> 30) / 210;
        sum  = sum - term;
        if (sum > 64'd1073741824) begin
            sum = 64'd1073741824;
        end
        sq = (sum * sum + (64'd1 << 43)) >> 44;
        return sq[MU_W-1:0];
    endfunction

    // a + (b - a) * mu / 2^16, rounded half up
    function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic [MU_W-1:0] mu);
        logic signed [32:0] d;
        logic signed [50:0] p;
        d = 33'(b) - 33'(a);
        p = d * $signed({1'b0, mu});
        p = p + 51'sd32768;
        return a + 32'(p >>> 16);
    endfunction

endpackage
`default_nettype wire

// ----- src/fractal_value_noise_height.sv -----
// Fractal value-noise terrain height.
// Input words (local_x, local_z, chunk_x, chunk_z) arrive on a valid/ready
// channel; each gives one height word (unsigned, 8 fraction bits) on the
// output valid/ready channel, in order.
// Throughput: one word per cycle while the output is not stalled. The
// pipeline is the bit-serial coordinate divider row of QW cells (one
// quotient bit per cell), QW = $clog2(32768*CHUNK_EDGE+64) + MAX_OCTAVES-2
// + CURVE_TABLE_BITS, followed by the row of octave cells (hash, blend
// and weight pipeline of nine stages each).
// Stall: the whole pipeline holds while the output register is full and
// i_ready is low; o_ready then drops, and nothing is lost or repeated.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while no word is in flight; the block does not enforce
// this. Unknown indexes are ignored. Reset (synchronous, active low) empties
// the pipeline and loads the register defaults; there is no clearing pass.
`default_nettype none
module fractal_value_noise_height import fvnh_pkg::*; #(
    parameter int CHUNK_EDGE       = CHUNK_EDGE_DEF,
    parameter int MAX_OCTAVES      = MAX_OCTAVES_DEF,
    parameter int CURVE_TABLE_BITS = CURVE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [5:0]            i_local_x,
    input  wire logic [5:0]            i_local_z,
    input  wire logic signed [15:0]    i_chunk_x,
    input  wire logic signed [15:0]    i_chunk_z,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_W-1:0]           o_height_q8,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW   = $clog2(32768 * CHUNK_EDGE + 64);
    localparam int WS   = WW + 2;
    localparam int FW   = MAX_OCTAVES - 2 + CURVE_TABLE_BITS;
    localparam int QW   = WW + FW;
    localparam int NOCT = MAX_OCTAVES - 1;
    localparam int TW   = 48 + $clog2(MAX_OCTAVES);

    logic [4:0]         r_oct;
    logic [9:0]         r_amp;
    logic [15:0]        r_smooth;
    logic signed [9:0]  r_off;
    logic [15:0]        r_rough;
    logic [31:0]        r_seed;
    logic [7:0]         r_wl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct    <= RST_OCTAVES;
            r_amp    <= RST_AMPLITUDE;
            r_smooth <= RST_SMOOTHNESS;
            r_off    <= RST_OFFSET;
            r_rough  <= RST_ROUGHNESS;
            r_seed   <= RST_SEED;
            r_wl     <= RST_WATER;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_OCTAVES:    r_oct    <= i_cfg_data[4:0];
                REG_AMPLITUDE:  r_amp    <= i_cfg_data[9:0];
                REG_SMOOTHNESS: r_smooth <= i_cfg_data[15:0];
                REG_OFFSET:     r_off    <= $signed(i_cfg_data[9:0]);
                REG_ROUGHNESS:  r_rough  <= i_cfg_data[15:0];
                REG_SEED:       r_seed   <= i_cfg_data;
                REG_WATER:      r_wl     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // world position
    logic signed [WS-1:0] w_wx, w_wz;
    assign w_wx = WS'($signed({1'b0, i_local_x})) + WS'(i_chunk_x) * WS'(CHUNK_EDGE);
    assign w_wz = WS'($signed({1'b0, i_local_z})) + WS'(i_chunk_z) * WS'(CHUNK_EDGE);

    t_ctl          r_in_ctl;
    logic [WW-1:0] r_in_wx, r_in_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_en) begin
            r_in_ctl <= '{valid: i_valid, neg: (w_wx[WS-1] || w_wz[WS-1])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_wx <= w_wx[WW-1:0];
            r_in_wz <= w_wz[WW-1:0];
        end
    end

    logic [15:0] w_div;
    assign w_div = (r_smooth == 16'd0) ? 16'd1 : r_smooth;

    // divider row: world / smoothness with FW fraction bits
    t_ctl          c_dctl [QW+1];
    logic [15:0]   c_rx   [QW+1];
    logic [15:0]   c_rz   [QW+1];
    logic [QW-1:0] c_qx   [QW+1];
    logic [QW-1:0] c_qz   [QW+1];

    assign c_dctl[0] = r_in_ctl;
    assign c_rx[0]   = '0;
    assign c_rz[0]   = '0;
    assign c_qx[0]   = {r_in_wx, {FW{1'b0}}};
    assign c_qz[0]   = {r_in_wz, {FW{1'b0}}};

    for (genvar g = 0; g < QW; g++) begin : g_div
        fvnh_div_cell #(.QW(QW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_div),
            .i_ctl   (c_dctl[g]),
            .i_rx    (c_rx[g]),
            .i_qx    (c_qx[g]),
            .i_rz    (c_rz[g]),
            .i_qz    (c_qz[g]),
            .o_ctl   (c_dctl[g+1]),
            .o_rx    (c_rx[g+1]),
            .o_qx    (c_qx[g+1]),
            .o_rz    (c_rz[g+1]),
            .o_qz    (c_qz[g+1])
        );
    end

    // number of octaves summed
    logic [4:0] w_oc_sat, w_cnt;
    assign w_oc_sat = (r_oct > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : r_oct;
    assign w_cnt    = (w_oc_sat == 5'd0) ? 5'd0 : 5'(w_oc_sat - 5'd1);

    t_ctl                 c_octl [NOCT+1];
    logic [QW-1:0]        c_oqx  [NOCT+1];
    logic [QW-1:0]        c_oqz  [NOCT+1];
    logic signed [TW-1:0] c_tot  [NOCT+1];
    logic [WT_W-1:0]      c_w    [NOCT+1];

    assign c_octl[0] = c_dctl[QW];
    assign c_oqx[0]  = c_qx[QW];
    assign c_oqz[0]  = c_qz[QW];
    assign c_tot[0]  = '0;
    assign c_w[0]    = WT_ONE;

    for (genvar g = 0; g < NOCT; g++) begin : g_oct
        fvnh_octave_cell #(
            .A   (g),
            .QW  (QW),
            .FW  (FW),
            .CTB (CURVE_TABLE_BITS),
            .TW  (TW)
        ) u_oct (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cnt   (w_cnt),
            .i_seed  (r_seed),
            .i_rough (r_rough),
            .i_w     (c_w[g]),
            .o_w     (c_w[g+1]),
            .i_ctl   (c_octl[g]),
            .i_qx    (c_oqx[g]),
            .i_qz    (c_oqz[g]),
            .i_total (c_tot[g]),
            .o_ctl   (c_octl[g+1]),
            .o_qx    (c_oqx[g+1]),
            .o_qz    (c_oqz[g+1]),
            .o_total (c_tot[g+1])
        );
    end

    fvnh_out_stage #(.TW(TW)) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (c_octl[NOCT]),
        .i_total  (c_tot[NOCT]),
        .i_amp    (r_amp),
        .i_off    (r_off),
        .i_wl     (r_wl),
        .o_valid  (o_valid),
        .o_height (o_height_q8)
    );

endmodule
`default_nettype wire

// ----- src/fvnh_div_cell.sv -----
`default_nettype none
module fvnh_div_cell import fvnh_pkg::*; #(
    parameter int QW = 46
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [15:0]   i_div,
    input  wire t_ctl          i_ctl,
    input  wire logic [15:0]   i_rx,
    input  wire logic [QW-1:0] i_qx,
    input  wire logic [15:0]   i_rz,
    input  wire logic [QW-1:0] i_qz,
    output t_ctl               o_ctl,
    output logic [15:0]        o_rx,
    output logic [QW-1:0]      o_qx,
    output logic [15:0]        o_rz,
    output logic [QW-1:0]      o_qz
);

    t_ctl          r_ctl;
    logic [15:0]   r_rx, r_rz;
    logic [QW-1:0] r_qx, r_qz;
    logic [16:0]   w_tx, w_tz;
    logic          w_gx, w_gz;

    // one restoring step per axis: dividend bit leaves the top of q, quotient bit enters at the bottom
    assign w_tx = {i_rx, i_qx[QW-1]};
    assign w_tz = {i_rz, i_qz[QW-1]};
    assign w_gx = (w_tx >= {1'b0, i_div});
    assign w_gz = (w_tz >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx <= w_gx ? 16'(w_tx - {1'b0, i_div}) : w_tx[15:0];
            r_rz <= w_gz ? 16'(w_tz - {1'b0, i_div}) : w_tz[15:0];
            r_qx <= {i_qx[QW-2:0], w_gx};
            r_qz <= {i_qz[QW-2:0], w_gz};
        end
    end

    assign o_ctl = r_ctl;
    assign o_rx  = r_rx;
    assign o_qx  = r_qx;
    assign o_rz  = r_rz;
    assign o_qz  = r_qz;

endmodule
`default_nettype wire

// ----- src/fvnh_octave_cell.sv -----
`default_nettype none
module fvnh_octave_cell import fvnh_pkg::*; #(
    parameter int A   = 0,
    parameter int QW  = 46,
    parameter int FW  = 24,
    parameter int CTB = 10,
    parameter int TW  = 52
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [4:0]           i_cnt,
    input  wire logic [31:0]          i_seed,
    input  wire logic [15:0]          i_rough,
    input  wire logic [WT_W-1:0]      i_w,
    output logic [WT_W-1:0]           o_w,
    input  wire t_ctl                 i_ctl,
    input  wire logic [QW-1:0]        i_qx,
    input  wire logic [QW-1:0]        i_qz,
    input  wire logic signed [TW-1:0] i_total,
    output t_ctl                      o_ctl,
    output logic [QW-1:0]             o_qx,
    output logic [QW-1:0]             o_qz,
    output logic signed [TW-1:0]      o_total
);

    localparam int SH  = FW - A;
    localparam int DEP = 9;
    localparam logic [31:0] OFS [4] = '{32'd0, 32'd1, 32'd57, 32'd58};

    logic [MU_W-1:0] w_mu_tab [1<<CTB];

    for (genvar g = 0; g < (1 << CTB); g++) begin : g_tab
        assign w_mu_tab[g] = curve_mu(g, CTB);
    end

    logic [31:0]     w_ix, w_iz;
    logic [CTB-1:0]  w_cx, w_cz;
    logic [32:0]     w_wprod;
    logic            w_on;
    logic signed [TW-1:0] w_term;

    t_ctl                 r_ctl_d [DEP];
    logic [QW-1:0]        r_qx_d  [DEP];
    logic [QW-1:0]        r_qz_d  [DEP];
    logic signed [TW-1:0] r_tot_d [DEP-1];
    logic signed [TW-1:0] r_tot;
    logic [WT_W-1:0]      r_w;

    logic [31:0]          r_n1;
    logic [31:0]          r_m2 [4];
    logic [31:0]          r_m3 [4];
    logic [31:0]          r_p3 [4];
    logic [31:0]          r_m4 [4];
    logic [31:0]          r_t4 [4];
    logic signed [31:0]   r_v5 [4];
    logic [MU_W-1:0]      r_mx1, r_mx2, r_mx3, r_mx4, r_mx5;
    logic [MU_W-1:0]      r_mz1, r_mz2, r_mz3, r_mz4, r_mz5, r_mz6;
    logic signed [31:0]   r_r1, r_r2, r_nz;
    logic signed [49:0]   r_wp;

    assign w_ix = 32'(i_qx >> SH);
    assign w_iz = 32'(i_qz >> SH);
    assign w_cx = CTB'(i_qx >> (SH - CTB));
    assign w_cz = CTB'(i_qz >> (SH - CTB));
    assign w_on = (5'(A) < i_cnt);
    assign w_term = w_on ? TW'(r_wp) : '0;

    // weight for the next octave, registered from this weight and the roughness
    assign w_wprod = 33'(i_w) * 33'(i_rough) + 33'd32768;

    always_ff @(posedge i_clk) begin
        r_w <= w_wprod[32:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEP; k++) begin
                r_ctl_d[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl_d[0] <= i_ctl;
            for (int k = 1; k < DEP; k++) begin
                r_ctl_d[k] <= r_ctl_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx_d[0]  <= i_qx;
            r_qz_d[0]  <= i_qz;
            r_tot_d[0] <= i_total;
            for (int k = 1; k < DEP; k++) begin
                r_qx_d[k] <= r_qx_d[k-1];
                r_qz_d[k] <= r_qz_d[k-1];
            end
            for (int k = 1; k < DEP - 1; k++) begin
                r_tot_d[k] <= r_tot_d[k-1];
            end
            r_tot <= r_tot_d[DEP-2] + w_term;

            // lattice index and curve lookups
            r_n1  <= w_ix + w_iz * 32'd57 + i_seed;
            r_mx1 <= w_mu_tab[w_cx];
            r_mz1 <= w_mu_tab[w_cz];

            // corner hashes
            for (int k = 0; k < 4; k++) begin
                r_m2[k] <= ((r_n1 + OFS[k]) << 13) ^ (r_n1 + OFS[k]);
                r_p3[k] <= r_m2[k] * r_m2[k];
                r_m3[k] <= r_m2[k];
                r_t4[k] <= r_p3[k] * HASH_MUL + HASH_ADD1;
                r_m4[k] <= r_m3[k];
                r_v5[k] <= ONE_Q30 - $signed({1'b0, 31'(r_m4[k] * r_t4[k] + HASH_ADD2)});
            end
            r_mx2 <= r_mx1;
            r_mx3 <= r_mx2;
            r_mx4 <= r_mx3;
            r_mx5 <= r_mx4;
            r_mz2 <= r_mz1;
            r_mz3 <= r_mz2;
            r_mz4 <= r_mz3;
            r_mz5 <= r_mz4;
            r_mz6 <= r_mz5;

            // interpolation along x, then z, then weighting
            r_r1 <= blend(r_v5[0], r_v5[1], r_mx5);
            r_r2 <= blend(r_v5[2], r_v5[3], r_mx5);
            r_nz <= blend(r_r1, r_r2, r_mz6);
            r_wp <= r_nz * $signed({1'b0, i_w});
        end
    end

    assign o_w     = r_w;
    assign o_ctl   = r_ctl_d[DEP-1];
    assign o_qx    = r_qx_d[DEP-1];
    assign o_qz    = r_qz_d[DEP-1];
    assign o_total = r_tot;

endmodule
`default_nettype wire

// ----- src/fvnh_out_stage.sv -----
`default_nettype none
module fvnh_out_stage import fvnh_pkg::*; #(
    parameter int TW = 52
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_ctl                 i_ctl,
    input  wire logic signed [TW-1:0] i_total,
    input  wire logic [9:0]           i_amp,
    input  wire logic signed [9:0]    i_off,
    input  wire logic [7:0]           i_wl,
    output logic                      o_valid,
    output logic [OUT_W-1:0]          o_height
);

    localparam int T30_W = TW - 16;
    localparam int PW    = T30_W + 11;
    localparam int NW    = TW + 4;

    t_ctl                    r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5;
    logic signed [T30_W-1:0] r_t30;
    logic signed [PW-1:0]    r_pa;
    logic signed [NW-1:0]    r_c;
    logic signed [NW-1:0]    r_num;
    logic [QUOT_W-1:0]       r_x4;
    logic                    r_sat4, r_npos4, r_sat5, r_npos5;
    logic [54:0]             r_prod5;
    logic                    r_valid;
    logic [OUT_W-1:0]        r_height;

    logic signed [TW:0]      w_tr;
    logic signed [NW:0]      w_nplus;
    logic [OUT_W-1:0]        w_water;
    logic [OUT_W-1:0]        n_height;

    assign w_tr    = (TW+1)'(i_total) + (TW+1)'(32768);
    assign w_nplus = (NW+1)'(r_num) + (NW+1)'(DEN_HALF);
    assign w_water = (i_wl == 8'd0) ? '0 : {4'd0, 8'(i_wl - 8'd1), 8'd0};

    always_comb begin
        if (r_ctl5.neg) begin
            n_height = w_water;
        end else if (r_npos5) begin
            n_height = OUT_ONE;
        end else if (r_sat5) begin
            n_height = OUT_MAX;
        end else begin
            n_height = r_prod5[RECIP_SHIFT +: OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1  <= '0;
            r_ctl2  <= '0;
            r_ctl3  <= '0;
            r_ctl4  <= '0;
            r_ctl5  <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_ctl1  <= i_ctl;
            r_ctl2  <= r_ctl1;
            r_ctl3  <= r_ctl2;
            r_ctl4  <= r_ctl3;
            r_ctl5  <= r_ctl4;
            r_valid <= r_ctl5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t30   <= T30_W'(w_tr >>> 16);
            r_pa    <= PW'(r_t30) * PW'($signed({1'b0, i_amp}));
            r_c     <= ((NW'($signed({1'b0, i_amp})) * NW'(AMP_K)) <<< DEN_SHIFT)
                     + ((NW'(i_off) * NW'(OFF_K)) <<< DEN_SHIFT);
            r_num   <= NW'(r_pa) * NW'(SCALE_K) + r_c;
            r_x4    <= w_nplus[DEN_SHIFT +: QUOT_W];
            r_sat4  <= (w_nplus >= (NW+1)'(SAT_LIM));
            r_npos4 <= r_num[NW-1] || (r_num == '0);
            r_prod5 <= 55'(r_x4) * 55'(RECIP);
            r_sat5  <= r_sat4;
            r_npos5 <= r_npos4;
            r_height <= n_height;
        end
    end

    assign o_valid  = r_valid;
    assign o_height = r_height;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import fvnh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [5:0]            i_local_x;
    logic [5:0]            i_local_z;
    logic signed [15:0]    i_chunk_x;
    logic signed [15:0]    i_chunk_z;
    logic                  o_valid;
    logic                  i_ready;
    logic [OUT_W-1:0]      o_height_q8;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fractal_value_noise_height dut (.*);

    // shadow copy of the configuration registers
    bit [4:0]         oct_setting;
    bit [9:0]         amp_reg;
    bit [15:0]        smooth_reg;
    bit signed [9:0]  offset_reg;
    bit [15:0]        rough_reg;
    bit [31:0]        seed_reg;
    bit [7:0]         water_reg;

    logic [OUT_W-1:0] pending_heights[$];
    int               errors;
    int               words_sent;
    int               words_checked;
    int               idle_cycles;
    int               send_idle;
    int               recv_stall;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint lattice_value(bit [31:0] idx);
        bit [31:0] m;
        bit [31:0] h;
        m = idx + seed_reg;
        m = (m << 13) ^ m;
        h = (m * (m * m * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fff_ffff;
        return 64'sd1073741824 - longint'(h);
    endfunction

    // sin^2 of the scaled fraction, Q16
    function automatic longint ease_weight(bit [63:0] frac_idx);
        bit [63:0] phi;
        bit [63:0] phi2;
        bit [63:0] term;
        bit [63:0] acc;
        phi  = ((frac_idx & 64'h3ff) * 64'd1685774664) >> 10;
        phi2 = (phi * phi) >> 30;
        acc  = phi;
        term = phi;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * phi2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        if (acc > 64'd1073741824) acc = 64'd1073741824;
        return longint'((acc * acc + (64'd1 << 43)) >> 44);
    endfunction

    function automatic longint lerp_q30(longint a, longint b, longint mu);
        longint x;
        x = a * (65536 - mu) + b * mu;
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint octave_value(longint wx, longint wz, int oct, longint s);
        bit [63:0] nx;
        bit [63:0] nz;
        bit [31:0] ix;
        bit [31:0] iz;
        bit [31:0] base;
        longint    mx;
        longint    mz;
        nx   = 64'(wx) << oct;
        nz   = 64'(wz) << oct;
        ix   = 32'(nx / 64'(s));
        iz   = 32'(nz / 64'(s));
        mx   = ease_weight(((nx % 64'(s)) << 10) / 64'(s));
        mz   = ease_weight(((nz % 64'(s)) << 10) / 64'(s));
        base = ix + iz * 32'd57;
        return lerp_q30(lerp_q30(lattice_value(base), lattice_value(base + 1), mx),
                        lerp_q30(lattice_value(base + 57), lattice_value(base + 58), mx),
                        mz);
    endfunction

    function automatic logic [OUT_W-1:0] terrain_height(bit [5:0] lx, bit [5:0] lz,
                                                        bit signed [15:0] cx,
                                                        bit signed [15:0] cz);
        longint wx;
        longint wz;
        longint s;
        longint total46;
        longint total30;
        longint num;
        longint q;
        longint wt;
        int     count;
        wx = longint'(lx) + longint'(cx) * 32;
        wz = longint'(lz) + longint'(cz) * 32;
        if (wx < 0 || wz < 0) begin
            if (water_reg == 0) return '0;
            return OUT_W'((longint'(water_reg) - 1) << 8);
        end
        count   = (oct_setting > 16) ? 15 : (oct_setting >= 1 ? oct_setting - 1 : 0);
        s       = (smooth_reg == 0) ? 1 : longint'(smooth_reg);
        total46 = 0;
        wt      = 65536;
        for (int a = 0; a < count; a++) begin
            total46 += octave_value(wx, wz, a, s) * wt;
            wt = (wt * longint'(rough_reg) + 32768) >>> 16;
        end
        total30 = (total46 + 32768) >>> 16;
        num = total30 * longint'(amp_reg) * 50 + longint'(amp_reg) * 32256 * 4194304
            + longint'(offset_reg) * 26880 * 4194304;
        if (num <= 0) return OUT_ONE;
        q = (num + 220200960) / 440401920;
        if (q > 1048575) q = 1048575;
        return OUT_W'(q);
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker and handshake watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                words_checked++;
                if (pending_heights.size() == 0) begin
                    report_mismatch("unexpected word", o_height_q8, '0);
                end else begin
                    logic [OUT_W-1:0] want;
                    want = pending_heights.pop_front();
                    if (o_height_q8 !== want) report_mismatch("height_q8", o_height_q8, want);
                end
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_word(bit [5:0] lx, bit [5:0] lz, bit [15:0] cx, bit [15:0] cz);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_local_x <= lx;
        i_local_z <= lz;
        i_chunk_x <= cx;
        i_chunk_z <= cz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_heights.push_back(terrain_height(lx, lz, cx, cz));
        words_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_OCTAVES:    oct_setting = data[4:0];
            REG_AMPLITUDE:  amp_reg     = data[9:0];
            REG_SMOOTHNESS: smooth_reg  = data[15:0];
            REG_OFFSET:     offset_reg  = data[9:0];
            REG_ROUGHNESS:  rough_reg   = data[15:0];
            REG_SEED:       seed_reg    = data;
            REG_WATER:      water_reg   = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(bit [4:0] oc, bit [9:0] amp, bit [15:0] sm, bit [9:0] off,
                                 bit [15:0] rough, bit [31:0] sd, bit [7:0] water);
        write_reg(REG_OCTAVES, 32'(oc));
        write_reg(REG_AMPLITUDE, 32'(amp));
        write_reg(REG_SMOOTHNESS, 32'(sm));
        write_reg(REG_OFFSET, {22'h3fffff * off[9], off});
        write_reg(REG_ROUGHNESS, 32'(rough));
        write_reg(REG_SEED, sd);
        write_reg(REG_WATER, 32'(water));
    endtask

    task automatic test_reset_defaults();
        send_word(0, 0, 0, 0);
        send_word(63, 63, 16'h7fff, 16'h7fff);
        send_word(0, 0, 16'hffff, 0);        // just left of the origin: water
        send_word(63, 0, 16'hffff, 5);       // local offset makes x positive again
        send_word(0, 63, 0, 16'h8000);
        send_word(5, 7, 100, 200);
        wait_idle();
    endtask

    task automatic test_register_corners();
        load_settings(0, 120, 1035, 0, 49152, 0, 64);     // no octaves
        send_word(9, 9, 3, 3);
        wait_idle();
        write_reg(REG_OCTAVES, 31);                        // clamps to the max
        send_word(9, 9, 3, 3);
        wait_idle();
        write_reg(REG_SMOOTHNESS, 0);                      // treated as one
        send_word(33, 1, 12, 40);
        wait_idle();
        load_settings(5, 0, 1035, 10'h200, 49152, 32'h8000_0000, 0);
        send_word(1, 2, 7, 9);                             // non-positive height
        send_word(1, 2, 16'h8000, 9);                      // water level zero
        wait_idle();
        // index past the register list must be dropped
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(7);
        i_cfg_data <= 32'hffff_ffff;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_word(1, 2, 7, 9);
        wait_idle();
        load_settings(16, 1023, 1, 511, 65535, 32'h7fff_ffff, 255);  // saturation
        for (int i = 0; i < 6; i++)
            send_word(6'($urandom), 6'($urandom), 16'($urandom_range(2000)),
                      16'($urandom_range(2000)));
        send_word(4, 4, 16'hfff0, 1);
        wait_idle();
    endtask

    task automatic test_random_phase(int n, bit [4:0] oc, bit [9:0] amp, bit [15:0] sm,
                                     bit [9:0] off, bit [15:0] rough, bit [31:0] sd,
                                     bit [7:0] water);
        bit [15:0] cx;
        bit [15:0] cz;
        load_settings(oc, amp, sm, off, rough, sd, water);
        for (int i = 0; i < n; i++) begin
            // mostly non-negative world positions so the octave path is exercised
            if ($urandom_range(99) < 80) begin
                cx = 16'($urandom_range(32767));
                cz = 16'($urandom_range(32767));
                if ($urandom_range(1)) cx = 16'($urandom_range(64));
                if ($urandom_range(1)) cz = 16'($urandom_range(64));
            end else begin
                cx = 16'($urandom);
                cz = 16'($urandom);
            end
            send_word(6'($urandom), 6'($urandom), cx, cz);
        end
        wait_idle();
    endtask

    task automatic test_random_mix(int sidle, int rstall);
        send_idle  = sidle;
        recv_stall = rstall;
        test_random_phase(205, 5'($urandom_range(1, 16)), 10'($urandom_range(1023)),
                          16'($urandom_range(1, 4000)), 10'($urandom),
                          16'($urandom), $urandom, 8'($urandom_range(1, 255)));
        test_random_phase(205, 5'($urandom_range(2, 31)), 10'($urandom),
                          ($urandom_range(1)) ? 16'($urandom_range(1, 64)) : 16'($urandom),
                          10'($urandom), 16'($urandom), $urandom, 8'($urandom));
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_local_x  = '0;
        i_local_z  = '0;
        i_chunk_x  = '0;
        i_chunk_z  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        errors = 0; words_sent = 0; words_checked = 0; idle_cycles = 0;
        send_idle = 0; recv_stall = 0;
        oct_setting = 5; amp_reg = 120; smooth_reg = 1035; offset_reg = 0;
        rough_reg = 49152; seed_reg = 0; water_reg = 64;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_corners();
        test_random_mix(27, 84);
        test_random_mix(84, 27);
        test_random_mix(0, 0);

        $display("covered: %0d words sent, %0d heights checked", words_sent, words_checked);
        $display("register corners, water and saturation paths, three idle patterns");
        if (errors == 0 && pending_heights.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
